[hw/rtl/baro_pressure_temp_compensation_assert.svh]
// ============================================================================
// Assertion macros for the barometric compensation block
// Concurrent checks that run on clk and are disabled while arst_n is low.
// ============================================================================
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/bpc_pkg.sv]
// ============================================================================
// bpc_pkg
// Shared widths, register codes, structs and helpers for the barometric
// compensation pipeline.
// ============================================================================
package bpc_pkg;

	// Pipeline depth and configuration port geometry.
	localparam int NumStages = 11;
	localparam int NumCoef   = 6;
	localparam int AddrWidth = 5;
	localparam int DataWidth = 32;
	localparam int IdxWidth  = AddrWidth - 2;

	// Field and intermediate widths.
	localparam int RawW   = 24;
	localparam int CoefW  = 16;
	localparam int TempW  = 20;
	localparam int PressW = 32;
	localparam int DtW    = 25;
	localparam int ProdW  = 42;
	localparam int DtSqW  = 50;
	localparam int T2W    = 18;
	localparam int OffW   = 40;
	localparam int SensW  = 39;
	localparam int SqW    = 36;
	localparam int CorrW  = 39;
	localparam int SplitW = 20;
	localparam int PartW  = 44;
	localparam int FullW  = 63;
	localparam int QuotW  = 42;
	localparam int DiffW  = 43;

	// Temperature thresholds in hundredths of a degree.
	localparam int TempRef  = 2000;
	localparam int TempCold = -1500;

	// Register indexes on the configuration port.
	typedef enum logic [IdxWidth-1:0] {
		REG_SENS_BASE   = 3'd0,
		REG_OFF_BASE    = 3'd1,
		REG_SENS_TEMPCO = 3'd2,
		REG_OFF_TEMPCO  = 3'd3,
		REG_REF_TEMP    = 3'd4,
		REG_TEMP_SLOPE  = 3'd5
	} reg_idx_t;

	// Calibration words as held by the register file.
	typedef struct packed {
		logic [CoefW-1:0] sens_base;
		logic [CoefW-1:0] off_base;
		logic [CoefW-1:0] sens_tempco;
		logic [CoefW-1:0] off_tempco;
		logic [CoefW-1:0] ref_temp;
		logic [CoefW-1:0] temp_slope;
	} coef_t;

	// Per-stage load enables and valid flags; bit 0 is stage one.
	typedef struct packed {
		logic [NumStages-1:0] en;
		logic [NumStages-1:0] valid;
	} pipe_ctrl_t;

	// Compensated terms handed from the temperature section to the pressure section.
	typedef struct packed {
		logic signed [TempW-1:0] temp;
		logic signed [OffW-1:0]  off;
		logic signed [SensW-1:0] sens;
		logic [RawW-1:0]         d1;
	} comp_t;

	// Arithmetic right shift that rounds toward zero, as a signed division by 2^k.
	function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] x,
			input int unsigned k);
		logic signed [63:0] bias;
		bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (x + bias) >>> k;
	endfunction

endpackage

[hw/rtl/bpc_in_if.sv]
// ============================================================================
// bpc_in_if
// Raw sample channel: one pressure count and one temperature count per word.
// ============================================================================
interface bpc_in_if import bpc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [RawW-1:0] raw_pressure;
	logic [RawW-1:0] raw_temperature;

	modport source (output valid, raw_pressure, raw_temperature, input ready);
	modport sink (input valid, raw_pressure, raw_temperature, output ready);
endinterface

[hw/rtl/bpc_out_if.sv]
// ============================================================================
// bpc_out_if
// Result channel: compensated temperature and pressure per word.
// ============================================================================
interface bpc_out_if import bpc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [TempW-1:0]  temperature_centi;
	logic signed [PressW-1:0] pressure_pa;

	modport source (output valid, temperature_centi, pressure_pa, input ready);
	modport sink (input valid, temperature_centi, pressure_pa, output ready);
endinterface

[hw/rtl/bpc_regs.sv]
// ============================================================================
// bpc_regs
// APB register file holding the six calibration words.
// ============================================================================
module bpc_regs import bpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [DataWidth-1:0] pwdata,
	output logic [DataWidth-1:0] prdata,
	output logic                 pready,
	output coef_t                coef
);

	coef_t    coef_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[AddrWidth-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign coef   = coef_q;

	// Register writes; addresses past the last word are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_SENS_BASE:   coef_q.sens_base   <= pwdata[CoefW-1:0];
				REG_OFF_BASE:    coef_q.off_base    <= pwdata[CoefW-1:0];
				REG_SENS_TEMPCO: coef_q.sens_tempco <= pwdata[CoefW-1:0];
				REG_OFF_TEMPCO:  coef_q.off_tempco  <= pwdata[CoefW-1:0];
				REG_REF_TEMP:    coef_q.ref_temp    <= pwdata[CoefW-1:0];
				REG_TEMP_SLOPE:  coef_q.temp_slope  <= pwdata[CoefW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read mux; unmapped addresses read as zero.
	always_comb begin
		unique case (idx)
			REG_SENS_BASE:   prdata = DataWidth'(coef_q.sens_base);
			REG_OFF_BASE:    prdata = DataWidth'(coef_q.off_base);
			REG_SENS_TEMPCO: prdata = DataWidth'(coef_q.sens_tempco);
			REG_OFF_TEMPCO:  prdata = DataWidth'(coef_q.off_tempco);
			REG_REF_TEMP:    prdata = DataWidth'(coef_q.ref_temp);
			REG_TEMP_SLOPE:  prdata = DataWidth'(coef_q.temp_slope);
			default:         prdata = '0;
		endcase
	end

endmodule

[hw/rtl/bpc_ctrl.sv]
// ============================================================================
// bpc_ctrl
// Valid tracking and per-stage load enables for the compensation pipeline.
// ============================================================================
module bpc_ctrl import bpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_ready,
	output logic       in_ready,
	output pipe_ctrl_t ctrl
);

	logic [NumStages-1:0] valid_q;
	logic [NumStages:0]   en;

	// A stage loads when it is empty or when its word moves on, so bubbles collapse.
	always_comb begin
		en[NumStages] = out_ready;
		for (int k = NumStages - 1; k >= 0; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	// Valid flags advance together with the data they describe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (en[NumStages-1:0] & {valid_q[NumStages-2:0], in_valid})
				| (~en[NumStages-1:0] & valid_q);
		end
	end

	assign in_ready   = en[0];
	assign ctrl.en    = en[NumStages-1:0];
	assign ctrl.valid = valid_q;

endmodule

[hw/rtl/bpc_comp.sv]
// ============================================================================
// bpc_comp
// Stages one to six: temperature delta, first-order terms and the cold
// second-order corrections of temperature, offset and sensitivity.
// ============================================================================
module bpc_comp import bpc_pkg::*; (
	input  logic            clk,
	input  pipe_ctrl_t      ctrl,
	input  coef_t           coef,
	input  logic [RawW-1:0] raw_pressure,
	input  logic [RawW-1:0] raw_temperature,
	output comp_t           comp
);

	// Stage one: difference to the reference temperature.
	logic signed [DtW-1:0] dt_s1;
	logic [RawW-1:0]       d1_s1;

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			dt_s1 <= DtW'($signed({2'b0, raw_temperature})
				- $signed({2'b0, coef.ref_temp, 8'b0}));
			d1_s1 <= raw_pressure;
		end
	end

	// Stage two: the four products with the temperature delta.
	logic signed [ProdW-1:0] p6_s2;
	logic signed [ProdW-1:0] p4_s2;
	logic signed [ProdW-1:0] p3_s2;
	logic signed [DtSqW-1:0] dtsq_s2;
	logic [RawW-1:0]         d1_s2;

	always_ff @(posedge clk) begin
		if (ctrl.en[1]) begin
			p6_s2   <= dt_s1 * $signed({1'b0, coef.temp_slope});
			p4_s2   <= dt_s1 * $signed({1'b0, coef.off_tempco});
			p3_s2   <= dt_s1 * $signed({1'b0, coef.sens_tempco});
			dtsq_s2 <= dt_s1 * dt_s1;
			d1_s2   <= d1_s1;
		end
	end

	// Stage three: first-order temperature, offset and sensitivity.
	logic signed [TempW-1:0] temp1_s3;
	logic signed [OffW-1:0]  off1_s3;
	logic signed [SensW-1:0] sens1_s3;
	logic [T2W-1:0]          t2_s3;
	logic [RawW-1:0]         d1_s3;

	always_ff @(posedge clk) begin
		if (ctrl.en[2]) begin
			temp1_s3 <= TempW'(TempRef + trunc_shr(64'(p6_s2), 23));
			off1_s3  <= OffW'($signed({1'b0, coef.off_base, 16'b0})
				+ trunc_shr(64'(p4_s2), 7));
			sens1_s3 <= SensW'($signed({1'b0, coef.sens_base, 15'b0})
				+ trunc_shr(64'(p3_s2), 8));
			t2_s3    <= dtsq_s2[30+T2W:31];
			d1_s3    <= d1_s2;
		end
	end

	// Stage four: squared distances to both thresholds and the threshold tests.
	logic signed [TempW-1:0] dist_ref;
	logic signed [TempW-1:0] dist_cold;
	logic signed [TempW-1:0] temp1_s4;
	logic signed [OffW-1:0]  off1_s4;
	logic signed [SensW-1:0] sens1_s4;
	logic [T2W-1:0]          t2_s4;
	logic [RawW-1:0]         d1_s4;
	logic [SqW-1:0]          a2_s4;
	logic [SqW-1:0]          b2_s4;
	logic                    below_ref_s4;
	logic                    below_cold_s4;

	assign dist_ref  = temp1_s3 - TempW'(TempRef);
	assign dist_cold = temp1_s3 - TempW'(TempCold);

	always_ff @(posedge clk) begin
		if (ctrl.en[3]) begin
			a2_s4         <= SqW'(dist_ref) * SqW'(dist_ref);
			b2_s4         <= SqW'(dist_cold) * SqW'(dist_cold);
			below_ref_s4  <= temp1_s3 < TempW'(TempRef);
			below_cold_s4 <= temp1_s3 < TempW'(TempCold);
			temp1_s4      <= temp1_s3;
			off1_s4       <= off1_s3;
			sens1_s4      <= sens1_s3;
			t2_s4         <= t2_s3;
			d1_s4         <= d1_s3;
		end
	end

	// Stage five: second-order offset and sensitivity terms, corrected temperature.
	logic [CorrW-1:0]        a2_x5;
	logic [CorrW-1:0]        b2_x7;
	logic [CorrW-1:0]        b2_x11;
	logic [CorrW-1:0]        off2_c;
	logic [CorrW-1:0]        sens2_c;
	logic signed [TempW-1:0] temp_s5;
	logic signed [OffW-1:0]  off1_s5;
	logic signed [SensW-1:0] sens1_s5;
	logic [CorrW-1:0]        off2_s5;
	logic [CorrW-1:0]        sens2_s5;
	logic [RawW-1:0]         d1_s5;

	always_comb begin
		a2_x5   = (CorrW'(a2_s4) << 2) + CorrW'(a2_s4);
		b2_x7   = (CorrW'(b2_s4) << 3) - CorrW'(b2_s4);
		b2_x11  = (CorrW'(b2_s4) << 3) + (CorrW'(b2_s4) << 1) + CorrW'(b2_s4);
		off2_c  = (a2_x5 >> 1) + (below_cold_s4 ? b2_x7 : '0);
		sens2_c = (a2_x5 >> 2) + (below_cold_s4 ? (b2_x11 >> 1) : '0);
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[4]) begin
			temp_s5  <= below_ref_s4 ? temp1_s4 - $signed({2'b0, t2_s4}) : temp1_s4;
			off2_s5  <= below_ref_s4 ? off2_c : '0;
			sens2_s5 <= below_ref_s4 ? sens2_c : '0;
			off1_s5  <= off1_s4;
			sens1_s5 <= sens1_s4;
			d1_s5    <= d1_s4;
		end
	end

	// Stage six: apply the second-order terms.
	logic signed [TempW-1:0] temp_s6;
	logic signed [OffW-1:0]  off_s6;
	logic signed [SensW-1:0] sens_s6;
	logic [RawW-1:0]         d1_s6;

	always_ff @(posedge clk) begin
		if (ctrl.en[5]) begin
			temp_s6 <= temp_s5;
			off_s6  <= off1_s5 - $signed({1'b0, off2_s5});
			sens_s6 <= SensW'(sens1_s5 - $signed({1'b0, sens2_s5}));
			d1_s6   <= d1_s5;
		end
	end

	assign comp.temp = temp_s6;
	assign comp.off  = off_s6;
	assign comp.sens = sens_s6;
	assign comp.d1   = d1_s6;

endmodule

[hw/rtl/bpc_press.sv]
// ============================================================================
// bpc_press
// Stages seven to eleven: split pressure product, scaling, offset removal
// and saturation to 32 bits.
// ============================================================================
module bpc_press import bpc_pkg::*; (
	input  logic                     clk,
	input  pipe_ctrl_t               ctrl,
	input  comp_t                    comp,
	output logic signed [TempW-1:0]  temperature_centi,
	output logic signed [PressW-1:0] pressure_pa
);

	// Stage seven: raw count times sensitivity as two partial products.
	logic [PartW-1:0]        lo_s7;
	logic signed [PartW-1:0] hi_s7;
	logic signed [OffW-1:0]  off_s7;
	logic signed [TempW-1:0] temp_s7;

	always_ff @(posedge clk) begin
		if (ctrl.en[6]) begin
			lo_s7   <= PartW'(comp.d1) * PartW'(comp.sens[SplitW-1:0]);
			hi_s7   <= $signed({1'b0, comp.d1}) * $signed(comp.sens[SensW-1:SplitW]);
			off_s7  <= comp.off;
			temp_s7 <= comp.temp;
		end
	end

	// Stage eight: recombine the partial products.
	logic signed [FullW-1:0] prod_s8;
	logic signed [OffW-1:0]  off_s8;
	logic signed [TempW-1:0] temp_s8;

	always_ff @(posedge clk) begin
		if (ctrl.en[7]) begin
			prod_s8 <= FullW'((64'(hi_s7) <<< SplitW) + 64'(lo_s7));
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;
		end
	end

	// Stage nine: scale by 2^21 toward zero.
	logic signed [QuotW-1:0] q_s9;
	logic signed [OffW-1:0]  off_s9;
	logic signed [TempW-1:0] temp_s9;

	always_ff @(posedge clk) begin
		if (ctrl.en[8]) begin
			q_s9    <= QuotW'(trunc_shr(64'(prod_s8), 21));
			off_s9  <= off_s8;
			temp_s9 <= temp_s8;
		end
	end

	// Stage ten: remove the offset.
	logic signed [DiffW-1:0] r_s10;
	logic signed [TempW-1:0] temp_s10;

	always_ff @(posedge clk) begin
		if (ctrl.en[9]) begin
			r_s10    <= DiffW'(64'(q_s9) - 64'(off_s9));
			temp_s10 <= temp_s9;
		end
	end

	// Stage eleven: scale by 2^15 toward zero and clamp to the signed 32-bit range.
	logic signed [63:0]       p_full;
	logic signed [PressW-1:0] p_sat;
	logic signed [PressW-1:0] pressure_s11;
	logic signed [TempW-1:0]  temp_s11;

	always_comb begin
		p_full = trunc_shr(64'(r_s10), 15);
		if (p_full > 64'sd2147483647) begin
			p_sat = {1'b0, {(PressW-1){1'b1}}};
		end else if (p_full < -64'sd2147483648) begin
			p_sat = {1'b1, {(PressW-1){1'b0}}};
		end else begin
			p_sat = p_full[PressW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[10]) begin
			pressure_s11 <= p_sat;
			temp_s11     <= temp_s10;
		end
	end

	assign temperature_centi = temp_s11;
	assign pressure_pa       = pressure_s11;

endmodule

[hw/rtl/baro_pressure_temp_compensation.sv]
// ============================================================================
// baro_pressure_temp_compensation
// Second-order compensation of raw barometric pressure and temperature
// counts into hundredths of a degree and pascals.
// ============================================================================
//
//   channel   direction  handshake        word
//   sample    in         valid / ready    raw_pressure, raw_temperature
//   result    out        valid / ready    temperature_centi, pressure_pa
//   apb       in         psel / penable   six 16-bit calibration words
//
// Eleven register stages; one word accepted per cycle unless a stalled result has filled them.
// The depth is set by the split 24x39 pressure product and the divisions
// toward zero, each of which holds a stage of its own.
// Reset clears the valid flags and the calibration words to zero.
// Each stage loads whenever it is empty, so a stalled result lets the
// stages behind it fill before sample.ready drops.
// ============================================================================

`include "baro_pressure_temp_compensation_assert.svh"

module baro_pressure_temp_compensation import bpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	bpc_in_if.sink               sample,
	bpc_out_if.source            result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [DataWidth-1:0] pwdata,
	output logic [DataWidth-1:0] prdata,
	output logic                 pready
);

	coef_t      coef;
	pipe_ctrl_t ctrl;
	comp_t      comp;
	logic       in_ready;

	// Calibration register file.
	bpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	// Pipeline valid flags and stage enables.
	bpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.out_ready (result.ready),
		.in_ready  (in_ready),
		.ctrl      (ctrl)
	);

	assign sample.ready = in_ready;
	assign result.valid = ctrl.valid[NumStages-1];

	// Temperature and correction terms.
	bpc_comp u_comp (
		.clk             (clk),
		.ctrl            (ctrl),
		.coef            (coef),
		.raw_pressure    (sample.raw_pressure),
		.raw_temperature (sample.raw_temperature),
		.comp            (comp)
	);

	// Pressure scaling and saturation.
	bpc_press u_press (
		.clk               (clk),
		.ctrl              (ctrl),
		.comp              (comp),
		.temperature_centi (result.temperature_centi),
		.pressure_pa       (result.pressure_pa)
	);

	// An accepted word must occupy the first stage on the next cycle.
	`BPC_ASSERT_NEXT(a_accept_fills_head, sample.valid && sample.ready, ctrl.valid[0], "accepted word missing from stage one")
	// An empty first stage must always take a word.
	`BPC_ASSERT_NOW(a_empty_head_ready, !ctrl.valid[0], sample.ready, "stage one empty but input not ready")
	// A full pipeline with a stalled result must hold off the input.
	`BPC_ASSERT_NOW(a_full_stall_blocks, (&ctrl.valid) && !result.ready, !sample.ready, "input taken while pipeline full and stalled")

endmodule
